@@ rtl/core/gsm7_pkg.sv @@
// Shared types, constants and the character-to-septet lookup for the GSM-7 septet packer.
// Depends on nothing; every module of the packer imports it.
package gsm7_pkg;

    localparam logic [7:0] LIMIT_CAP = 8'd160;
    localparam logic [7:0] NO_SEPTET = 8'hFF;
    localparam logic [7:0] MAX_CHARS_RESET = 8'd160;
    localparam int unsigned FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_result;
        status_t    status;
        logic [7:0] septet_count;
        logic [7:0] byte_count;
    } result_t;

    // Results produced by one character: zero, one or two of them.
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    // GSM 03.38 default alphabet for 7-bit ASCII, with the usual substitutions.
    function automatic logic [7:0] septet_of(input logic [6:0] code);
        logic [7:0] s;
        s = NO_SEPTET;
        priority if (code == 7'h0A || code == 7'h0D)
            s = {1'b0, code};
        else if (code == 7'h24)
            s = 8'h02;
        else if (code == 7'h40)
            s = 8'h00;
        else if (code == 7'h5B)
            s = 8'h3C;
        else if (code == 7'h5D)
            s = 8'h3E;
        else if (code == 7'h5F)
            s = 8'h11;
        else if (code >= 7'h20 && code <= 7'h3F)
            s = {1'b0, code};
        else if (code >= 7'h41 && code <= 7'h5A)
            s = {1'b0, code};
        else if (code >= 7'h61 && code <= 7'h7A)
            s = {1'b0, code};
        else
            s = NO_SEPTET;
        return s;
    endfunction

endpackage

@@ rtl/core/gsm7_pack_core.sv @@
// Message state and the single-pass septet packing step of the GSM-7 packer.
// Depends on gsm7_pkg for the septet lookup, result and push types.
module gsm7_pack_core
    import gsm7_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic [7:0] max_chars,
    output push_t      push
);

    logic [6:0] leftover_bits_reg, leftover_bits_next;
    logic [2:0] leftover_count_reg, leftover_count_next;
    logic [7:0] chars_seen_reg, chars_seen_next;
    logic [7:0] bytes_out_reg, bytes_out_next;
    logic       bad_char_reg, bad_char_next;

    logic [7:0]  limit;
    logic [7:0]  cs_inc;
    logic [7:0]  sept;
    logic        unmapped;
    logic        pack_ok;
    logic        do_pack;
    logic [13:0] acc;
    logic        full;
    logic [6:0]  new_bits;
    logic [2:0]  new_count;
    logic [7:0]  bytes_packed;
    logic        flush;
    logic [7:0]  bytes_total;
    logic        too_long;
    logic        err;
    result_t     zero_res;

    always_comb
    begin
        limit    = (max_chars < LIMIT_CAP) ? max_chars : LIMIT_CAP;
        cs_inc   = (chars_seen_reg <= limit) ? chars_seen_reg + 8'd1 : chars_seen_reg;
        sept     = char_code[7] ? NO_SEPTET : septet_of(char_code[6:0]);
        unmapped = (sept == NO_SEPTET);
        pack_ok  = (cs_inc <= limit) && !bad_char_reg;
        do_pack  = pack_ok && !unmapped;

        acc  = {7'b0, leftover_bits_reg} | ({7'b0, sept[6:0]} << leftover_count_reg);
        // Seven new bits complete a byte whenever any bits were pending.
        full = (leftover_count_reg != 3'd0);
        if (full)
        begin
            new_bits  = {1'b0, acc[13:8]};
            new_count = leftover_count_reg - 3'd1;
        end
        else
        begin
            new_bits  = acc[6:0];
            new_count = 3'd7;
        end

        bad_char_next = bad_char_reg | (pack_ok && unmapped);
        bytes_packed  = bytes_out_reg + {7'b0, (do_pack && full)};
        too_long      = (cs_inc > limit);
        err           = too_long || bad_char_next;
        flush         = (new_count != 3'd0);
        bytes_total   = bytes_packed + {7'b0, flush};

        zero_res = '{packed_byte: 8'd0, last_result: 1'b0, status: ST_OK,
                     septet_count: 8'd0, byte_count: 8'd0};
        push.n   = 2'd0;
        push.r0  = zero_res;
        push.r1  = zero_res;

        leftover_bits_next  = do_pack ? new_bits : leftover_bits_reg;
        leftover_count_next = do_pack ? new_count : leftover_count_reg;
        chars_seen_next     = cs_inc;
        bytes_out_next      = bytes_packed;

        if (!last_char)
        begin
            if (do_pack && full)
            begin
                push.n              = 2'd1;
                push.r0.packed_byte = acc[7:0];
            end
        end
        else
        begin
            // The last character always clears the message state.
            leftover_bits_next  = 7'd0;
            leftover_count_next = 3'd0;
            chars_seen_next     = 8'd0;
            bytes_out_next      = 8'd0;
            bad_char_next       = 1'b0;
            if (err)
            begin
                push.n              = 2'd1;
                push.r0.last_result = 1'b1;
                push.r0.status      = too_long ? ST_TOO_LONG : ST_BAD_CHAR;
            end
            else if (full && flush)
            begin
                push.n                = 2'd2;
                push.r0.packed_byte   = acc[7:0];
                push.r1.packed_byte   = {1'b0, new_bits};
                push.r1.last_result   = 1'b1;
                push.r1.septet_count  = cs_inc;
                push.r1.byte_count    = bytes_total;
            end
            else
            begin
                push.n                = 2'd1;
                push.r0.packed_byte   = full ? acc[7:0] : {1'b0, new_bits};
                push.r0.last_result   = 1'b1;
                push.r0.septet_count  = cs_inc;
                push.r0.byte_count    = bytes_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= 7'd0;
            leftover_count_reg <= 3'd0;
            chars_seen_reg     <= 8'd0;
            bytes_out_reg      <= 8'd0;
            bad_char_reg       <= 1'b0;
        end
        else if (step)
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
            chars_seen_reg     <= chars_seen_next;
            bytes_out_reg      <= bytes_out_next;
            bad_char_reg       <= bad_char_next;
        end
    end

endmodule

@@ rtl/core/gsm7_result_fifo.sv @@
// Four-entry result queue of the GSM-7 packer: takes up to two results a cycle, gives one.
// Depends on gsm7_pkg for the result and push types.
module gsm7_result_fifo
    import gsm7_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_en,
    input  push_t   push,
    input  logic    pop,
    output logic    room,
    output logic    not_empty,
    output result_t head
);

    localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
    localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

    result_t       entry_reg [FIFO_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] n_in;
    logic            do_pop;

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    // Two free entries are needed, since one character can make two results.
    assign room      = (count_reg <= CntW'(FIFO_DEPTH - 2));

    always_comb
    begin
        do_pop      = pop && not_empty;
        n_in        = push_en ? CntW'(push.n) : '0;
        wr_ptr_next = wr_ptr_reg + PtrW'(n_in);
        rd_ptr_next = rd_ptr_reg + PtrW'(do_pop);
        count_next  = count_reg + n_in - CntW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en && push.n != 2'd0)
            entry_reg[wr_ptr_reg] <= push.r0;
        if (push_en && push.n == 2'd2)
            entry_reg[wr_ptr_reg + PtrW'(1)] <= push.r1;
    end

endmodule

@@ rtl/core/gsm7_septet_packer_unit.sv @@
// Top level of the GSM-7 septet packer: input register, max_chars register, packing step
// and result queue. Depends on gsm7_pkg, gsm7_pack_core and gsm7_result_fifo.
//
//   Channel   Signals                                          Direction
//   -------   ----------------------------------------------   ---------
//   input     in_valid, in_ready, char_code, last_char          in
//   output    out_valid, out_ready, packed_byte, last_result,   out
//             status, septet_count, byte_count
//   config    cfg_wr_en, cfg_wr_data (max_chars)                in
//
// A request is taken into the input register; it is packed once the queue has two free
// entries, and its zero, one or two results are written into a four-entry result queue
// that drives the outputs. One request per cycle is accepted as long as the queue has two
// free entries, so the rate is one character per cycle whenever the consumer takes results
// as fast as they come.
// Reset clears the message state and the queue and sets max_chars to 160.
// A stalled consumer fills the queue, after which in_ready drops until entries drain.
module gsm7_septet_packer_unit
    import gsm7_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] packed_byte,
    output logic       last_result,
    output logic [1:0] status,
    output logic [7:0] septet_count,
    output logic [7:0] byte_count,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic       item_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic [7:0] max_chars_reg;
    logic       room;
    logic       advance;
    logic       in_take;
    push_t      push;
    result_t    head;

    // The held request moves on only when the queue can absorb both of its results.
    assign advance  = item_valid_reg && room;
    assign in_ready = !item_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            max_chars_reg  <= MAX_CHARS_RESET;
        end
        else
        begin
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (cfg_wr_en)
                max_chars_reg <= cfg_wr_data;
        end
    end

    // The character payload needs no reset; it is qualified by item_valid_reg.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    gsm7_pack_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (char_reg),
        .last_char (last_reg),
        .max_chars (max_chars_reg),
        .push      (push)
    );

    gsm7_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .pop       (out_ready),
        .room      (room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign packed_byte  = head.packed_byte;
    assign last_result  = head.last_result;
    assign status       = head.status;
    assign septet_count = head.septet_count;
    assign byte_count   = head.byte_count;

endmodule

@@ tb/tb_gsm7_septet_packer_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for gsm7_septet_packer_unit: a directed table, then random messages
// in several idle and stall phases, results checked against a local packing predictor or
// a typed value. Depends on gsm7_pkg and the gsm7_septet_packer_unit RTL.
module tb_gsm7_septet_packer_unit;
    import gsm7_pkg::*;

    // Pause after the last owed result arrives, a margin before the block is taken as drained.
    localparam int SETTLE_CYCLES   = 6;
    // Cycles with no request moved on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int PRESSURE_PHASE  = 4;
    localparam int RANDOM_LIMIT    = -1;
    localparam int MAX_PRINTED     = 40;

    // Per phase: max_chars to program, percent of cycles the sender idles and the
    // receiver stalls. RANDOM_LIMIT picks a fresh max_chars in the legal range.
    localparam int PHASE_MAX[NUM_PHASES]   = '{160, 12, 255, RANDOM_LIMIT, 1, 8};
    localparam int PHASE_IDLE[NUM_PHASES]  = '{0, 70, 0, 8, 0, 0};
    localparam int PHASE_STALL[NUM_PHASES] = '{0, 0, 70, 8, 0, 70};

    typedef enum logic [1:0] {
        ROW_CHAR,
        ROW_CHECKED,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table. ROW_CHECKED rows carry their single result typed in.
    typedef struct {
        row_kind_t  kind;
        logic [7:0] value;
        logic       is_last;
        result_t    want;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = 8'd0;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] packed_byte;
    logic       last_result;
    logic [1:0] status;
    logic [7:0] septet_count;
    logic [7:0] byte_count;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    // Predictor copy of the packing state and of the max_chars register.
    logic [7:0] char_limit_reg = MAX_CHARS_RESET;
    logic [6:0] pend_bits = 7'd0;
    logic [2:0] pend_nbits = 3'd0;
    logic [7:0] msg_chars = 8'd0;
    logic [7:0] msg_bytes = 8'd0;
    logic       msg_bad = 1'b0;

    // Packed bytes and final statuses still owed by the block, oldest first.
    result_t  awaited_results[$];
    dir_row_t directed_rows[$];

    int mismatch_count = 0;
    int requests_sent = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    gsm7_septet_packer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packed_byte  (packed_byte),
        .last_result  (last_result),
        .status       (status),
        .septet_count (septet_count),
        .byte_count   (byte_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // GSM 03.38 default alphabet for 7-bit ASCII. Backslash, caret, backquote, braces,
    // bar, tilde and most control codes have no septet here.
    function automatic logic [7:0] gsm_septet(input logic [6:0] c);
        logic [7:0] s;
        case (c)
            7'h24:        s = 8'h02;
            7'h40:        s = 8'h00;
            7'h5B:        s = 8'h3C;
            7'h5D:        s = 8'h3E;
            7'h5F:        s = 8'h11;
            7'h0A, 7'h0D: s = {1'b0, c};
            default:
            begin
                if ((c >= 7'h20 && c <= 7'h3F) || (c >= 7'h41 && c <= 7'h5A)
                    || (c >= 7'h61 && c <= 7'h7A))
                    s = {1'b0, c};
                else
                    s = NO_SEPTET;
            end
        endcase
        return s;
    endfunction

    function automatic logic [7:0] any_mappable();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 127));
        while (gsm_septet(c[6:0]) == NO_SEPTET);
        return c;
    endfunction

    function automatic logic [7:0] any_unmappable();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 1)
            c = 8'($urandom_range(128, 255));
        else
        begin
            do
                c = 8'($urandom_range(0, 127));
            while (gsm_septet(c[6:0]) != NO_SEPTET);
        end
        return c;
    endfunction

    // Packs one character and returns how many results it yields (0, 1 or 2) in
    // first and second. The message state is cleared after every last character.
    function automatic int pack_char(input logic [7:0] code, input logic is_last,
                                     output result_t first, output result_t second);
        logic [7:0]  limit;
        logic [7:0]  sept;
        logic [14:0] acc;
        logic [3:0]  nbits;
        logic [7:0]  done [0:1];
        int          n;
        limit = (char_limit_reg < LIMIT_CAP) ? char_limit_reg : LIMIT_CAP;
        n = 0;
        first = '0;
        second = '0;
        // The character count saturates one past the limit.
        if (msg_chars <= limit)
            msg_chars = msg_chars + 8'd1;
        if (msg_chars <= limit && !msg_bad)
        begin
            sept = code[7] ? NO_SEPTET : gsm_septet(code[6:0]);
            if (sept == NO_SEPTET)
                msg_bad = 1'b1;
            else
            begin
                // Septets go in LSB first above the bits still pending.
                acc = {8'd0, pend_bits} | ({8'd0, sept[6:0]} << pend_nbits);
                nbits = {1'b0, pend_nbits} + 4'd7;
                if (nbits >= 4'd8)
                begin
                    done[n] = acc[7:0];
                    n++;
                    msg_bytes = msg_bytes + 8'd1;
                    acc = acc >> 8;
                    nbits = nbits - 4'd8;
                end
                pend_bits = acc[6:0];
                pend_nbits = nbits[2:0];
            end
        end
        if (!is_last)
        begin
            if (n == 1)
                first.packed_byte = done[0];
            return n;
        end
        if (msg_chars > limit || msg_bad)
        begin
            // Too long wins over a bad character; the byte is zero on any error.
            first.last_result = 1'b1;
            if (msg_chars > limit)
                first.status = ST_TOO_LONG;
            else
                first.status = ST_BAD_CHAR;
            n = 1;
        end
        else
        begin
            // Flush the partial byte, zero-padded in its high bits.
            if (pend_nbits != 3'd0)
            begin
                done[n] = {1'b0, pend_bits};
                n++;
                msg_bytes = msg_bytes + 8'd1;
            end
            first.packed_byte = done[0];
            if (n == 2)
            begin
                second.packed_byte = done[1];
                second.last_result = 1'b1;
                second.septet_count = msg_chars;
                second.byte_count = msg_bytes;
            end
            else
            begin
                first.last_result = 1'b1;
                first.septet_count = msg_chars;
                first.byte_count = msg_bytes;
            end
        end
        pend_bits = 7'd0;
        pend_nbits = 3'd0;
        msg_chars = 8'd0;
        msg_bytes = 8'd0;
        msg_bad = 1'b0;
        return n;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [7:0] value,
                                    input logic is_last, input logic [7:0] want_byte,
                                    input status_t want_status, input logic [7:0] want_septets,
                                    input logic [7:0] want_bytes);
        dir_row_t row;
        row.kind = kind;
        row.value = value;
        row.is_last = is_last;
        row.want.packed_byte = want_byte;
        row.want.last_result = 1'b1;
        row.want.status = want_status;
        row.want.septet_count = want_septets;
        row.want.byte_count = want_bytes;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one request and holds it until accepted, idling first at the phase's rate.
    // A checked request queues its typed result; all others queue what the predictor gives.
    task automatic send_char(input logic [7:0] code, input logic is_last,
                             input logic checked, input result_t typed_result);
        result_t r0;
        result_t r1;
        int      n;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        last_char <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        n = pack_char(code, is_last, r0, r1);
        if (checked)
            awaited_results.push_back(typed_result);
        else
        begin
            if (n > 0)
                awaited_results.push_back(r0);
            if (n > 1)
                awaited_results.push_back(r1);
        end
        requests_sent++;
    endtask

    // Drops valid and waits until every owed result has come and the pipeline is empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_chars(input logic [7:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        char_limit_reg = value;
    endtask

    // One whole message. A fixed length gives a clean message of that many characters;
    // otherwise the mix is mostly clean short messages, some that run past or sit exactly
    // at a small limit, some with one bad character and some of raw noise bytes.
    task automatic send_message(input int fixed_len);
        int         eff;
        int         len;
        int         bad_at;
        int         roll;
        logic [7:0] c;
        eff = (char_limit_reg < LIMIT_CAP) ? int'(char_limit_reg) : int'(LIMIT_CAP);
        roll = (fixed_len > 0) ? 0 : int'($urandom_range(1, 100));
        bad_at = -1;
        if (fixed_len > 0)
            len = fixed_len;
        else if (roll <= 10 && eff <= 24)
            len = eff + int'($urandom_range(1, 3));
        else if (roll <= 16 && eff <= 24)
            len = eff;
        else
            len = int'($urandom_range(1, (eff < 24) ? eff : 24));
        // A bad character inside an overlong message checks that too long wins.
        if ((roll > 78 && roll <= 90) || (roll > 5 && roll <= 10))
            bad_at = int'($urandom_range(0, len - 1));
        for (int i = 0; i < len; i++)
        begin
            if (roll > 90)
                c = 8'($urandom_range(0, 255));
            else if (i == bad_at)
                c = any_unmappable();
            else
                c = any_mappable();
            send_char(c, i == len - 1, 1'b0, '0);
        end
    endtask

    // Receiver: checks each accepted result against the oldest expectation, then
    // decides out_ready for the next cycle. A hold-off request from the stimulus keeps
    // it low for a long stretch so the result queue fills and in_ready drops.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no request pending", packed_byte, -1);
                else
                begin
                    want = awaited_results.pop_front();
                    if (packed_byte != want.packed_byte)
                        report_mismatch("packed_byte", packed_byte, want.packed_byte);
                    if (last_result != want.last_result)
                        report_mismatch("last_result", last_result, want.last_result);
                    if (status != want.status)
                        report_mismatch("status", status, want.status);
                    if (septet_count != want.septet_count)
                        report_mismatch("septet_count", septet_count, want.septet_count);
                    if (byte_count != want.byte_count)
                        report_mismatch("byte_count", byte_count, want.byte_count);
                end
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog: a long run of cycles in which no request moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        dir_row_t row;
        int       phase_start;

        // Single characters with an obvious result: one septet, one byte; then the
        // unmappable ones (NUL, top code, lowest high code, DEL).
        add_row(ROW_CHECKED, 8'h41, 1'b1, 8'h41, ST_OK, 8'd1, 8'd1);
        add_row(ROW_CHECKED, 8'h00, 1'b1, 8'h00, ST_BAD_CHAR, 8'd0, 8'd0);
        add_row(ROW_CHECKED, 8'hFF, 1'b1, 8'h00, ST_BAD_CHAR, 8'd0, 8'd0);
        add_row(ROW_CHECKED, 8'h80, 1'b1, 8'h00, ST_BAD_CHAR, 8'd0, 8'd0);
        add_row(ROW_CHECKED, 8'h7F, 1'b1, 8'h00, ST_BAD_CHAR, 8'd0, 8'd0);
        // Every substitution plus line feed and carriage return: seven septets, so the
        // last character yields a completed byte and a flushed one.
        add_row(ROW_CHAR, 8'h24, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h40, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h5F, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h5B, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h5D, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h0A, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h0D, 1'b1, 8'h00, ST_OK, 8'd0, 8'd0);
        // Eight septets fill exactly seven bytes: nothing is left to flush.
        add_row(ROW_CHAR, 8'h7A, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h20, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h3F, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h5A, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h61, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h30, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h39, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h5A, 1'b1, 8'h00, ST_OK, 8'd0, 8'd0);
        // Limit of one: a bad character followed by a good one reports too long.
        add_row(ROW_CFG, 8'd1, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHAR, 8'h80, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHECKED, 8'h41, 1'b1, 8'h00, ST_TOO_LONG, 8'd0, 8'd0);
        // A limit of zero makes every message too long.
        add_row(ROW_CFG, 8'd0, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHECKED, 8'h41, 1'b1, 8'h00, ST_TOO_LONG, 8'd0, 8'd0);
        // A limit above 160 is capped, so a short message still passes.
        add_row(ROW_CFG, 8'd255, 1'b0, 8'h00, ST_OK, 8'd0, 8'd0);
        add_row(ROW_CHECKED, 8'h42, 1'b1, 8'h42, ST_OK, 8'd1, 8'd1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_CFG:     write_max_chars(row.value);
                ROW_CHECKED: send_char(row.value, row.is_last, 1'b1, row.want);
                default:     send_char(row.value, row.is_last, 1'b0, '0);
            endcase
        end

        // Random phases. Each starts idle with a new max_chars and its own idle and stall mix.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (PHASE_MAX[p] == RANDOM_LIMIT)
                write_max_chars(8'($urandom_range(1, 160)));
            else
                write_max_chars(8'(PHASE_MAX[p]));
            sender_idle_pct = PHASE_IDLE[p];
            receiver_stall_pct = PHASE_STALL[p];
            if (p == PRESSURE_PHASE)
                hold_request = HOLD_OFF_CYCLES;
            phase_start = requests_sent;
            // With the capped limit, one message of the full length and one just past it.
            if (PHASE_MAX[p] > int'(LIMIT_CAP))
            begin
                send_message(int'(LIMIT_CAP));
                send_message(int'(LIMIT_CAP) + 1);
            end
            while (requests_sent - phase_start < ITEMS_PER_PHASE)
                send_message(0);
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
